// ----- hdl/bsop_pkg.sv -----
// Shared types, codes and the object descriptor ROM for the sensor object parser.
// No dependencies; imported by ble_sensor_object_parser_top and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bsop_pkg;

    localparam int ROM_DEPTH = 80;
    localparam int ID_W      = 7;
    localparam int VALUE_W   = 32;
    localparam int RAW_W     = 33;
    localparam int LEN_W     = 3;
    localparam int EXP_W     = 2;
    localparam int OUT_DATA_W = 48;

    // Descriptor bits: length in 2..0, sign kind in 4..3, exponent in 6..5.
    localparam logic [1:0] SIGN_KIND_SIGNED = 2'b01;

    typedef enum logic [1:0] {
        ST_MEASURE = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_SHORT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_EXPECT = 3'b001,
        PH_VALUE  = 3'b010,
        PH_DROP   = 3'b100
    } phase_t;

    localparam logic [7:0] OBJ_ROM [0:ROM_DEPTH-1] = '{
        8'h01, 8'h01, 8'h4A, 8'h42, 8'h43, 8'h43, 8'h42, 8'h42,
        8'h4A, 8'h01, 8'h63, 8'h43, 8'h62, 8'h02, 8'h02, 8'h01,
        8'h01, 8'h01, 8'h02, 8'h02, 8'h42, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h04, 8'h2A,
        8'h02, 8'h22, 8'h63, 8'h62, 8'h42, 8'h2A, 8'h21, 8'h22,
        8'h02, 8'h62, 8'h22, 8'h63, 8'h64, 8'h64, 8'h64, 8'h64
    };

    // Descriptor lookup; ids past the end of the table read as zero.
    function automatic logic [7:0] obj_descriptor(input logic [ID_W-1:0] id);
        logic [7:0] word;
        word = 8'h00;
        if (int'(id) < ROM_DEPTH) begin
            word = OBJ_ROM[id];
        end
        return word;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ble_sensor_object_parser_top.sv -----
// Top level of the sensor advertisement object parser: input register, parse logic,
// result register. Depends on bsop_pkg for the descriptor ROM, codes and types.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a sensor advertisement payload one byte per item on the slave stream,
// with tlast on the final byte, and emits one result item per decoded object on the
// master stream. Each object is an id byte followed by one to four little-endian value
// bytes; an internal 80-entry descriptor table gives each id its length, signedness and
// decimal exponent, so the measured quantity is raw_value times ten to the minus
// decimal_exponent. Ids with zero length produce nothing. An unknown id, or a payload
// that ends inside an object, produces one error result whose value and exponent are
// zero, and the rest of an erroneous payload is discarded up to its tlast. The block
// accepts one byte every cycle while the master side takes results; a byte's result
// passes through the input register and then the result register before it is
// presented. The throughput of one byte per cycle is set by the single parse-state
// update each byte makes. No clearing pass is needed after reset.
module ble_sensor_object_parser_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // tdata fields from bit 0: payload_byte[7:0]
    input  wire logic [7:0]                      s_axis_tdata,
    // tlast carries last_byte
    input  wire logic                            s_axis_tlast,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata fields from bit 0: object_id[6:0], raw_value[39:7],
    // decimal_exponent[41:40], zero padding[47:42]
    output      logic [bsop_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser fields from bit 0: status[1:0]
    output      logic [1:0]                      m_axis_tuser
);
    import bsop_pkg::*;

    // Input register stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Parse state, updated once per byte taken from the input register.
    phase_t               phase_reg, phase_next;
    logic [ID_W-1:0]      cur_id_reg, cur_id_next;
    logic [LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]     value_length_reg, value_length_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 signed_reg, signed_next;
    logic [EXP_W-1:0]     exp_reg, exp_next;

    // Result register stage.
    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [RAW_W-1:0]     out_raw_reg;
    logic [EXP_W-1:0]     out_exp_reg;
    status_t              out_status_reg;

    // Combinational result of the byte in the input register.
    logic                 res_fire;
    logic [ID_W-1:0]      res_id;
    logic [RAW_W-1:0]     res_raw;
    logic [EXP_W-1:0]     res_exp;
    status_t              res_status;

    logic                 advance;
    logic                 take;
    logic [7:0]           desc;
    logic [LEN_W-1:0]     desc_len;
    logic [1:0]           pos;
    logic [VALUE_W-1:0]   shifted;
    logic [VALUE_W-1:0]   acc_merged;
    logic [LEN_W-1:0]     left_dec;
    logic [RAW_W-1:0]     ext_mask;
    logic                 top_bit;

    // The pipeline moves whenever the result register is free or being emptied.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign take          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign desc     = obj_descriptor(in_byte_reg[ID_W-1:0]);
    assign desc_len = desc[LEN_W-1:0];

    // Value byte placement and the finished, sign-extended value.
    assign pos        = value_length_reg[1:0] - bytes_left_reg[1:0];
    assign shifted    = {{(VALUE_W-8){1'b0}}, in_byte_reg} << {pos, 3'b000};
    assign acc_merged = acc_reg | shifted;
    assign left_dec   = bytes_left_reg - LEN_W'(1);

    always_comb
    begin
        unique case (value_length_reg)
            3'd1:
            begin
                top_bit  = acc_merged[7];
                ext_mask = {{(RAW_W-8){1'b1}}, 8'h00};
            end
            3'd2:
            begin
                top_bit  = acc_merged[15];
                ext_mask = {{(RAW_W-16){1'b1}}, 16'h0000};
            end
            3'd3:
            begin
                top_bit  = acc_merged[23];
                ext_mask = {{(RAW_W-24){1'b1}}, 24'h000000};
            end
            default:
            begin
                top_bit  = acc_merged[31];
                ext_mask = {{(RAW_W-32){1'b1}}, 32'h00000000};
            end
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        cur_id_next       = cur_id_reg;
        bytes_left_next   = bytes_left_reg;
        value_length_next = value_length_reg;
        acc_next          = acc_reg;
        signed_next       = signed_reg;
        exp_next          = exp_reg;
        res_fire          = 1'b0;
        res_id            = cur_id_reg;
        res_raw           = '0;
        res_exp           = '0;
        res_status        = ST_MEASURE;

        unique case (phase_reg)
            PH_EXPECT:
            begin
                if (int'(in_byte_reg) >= ROM_DEPTH) begin
                    res_fire   = 1'b1;
                    res_id     = in_byte_reg[ID_W-1:0];
                    res_status = ST_UNKNOWN;
                    phase_next = PH_DROP;
                end else begin
                    cur_id_next = in_byte_reg[ID_W-1:0];
                    // A zero-length id is skipped and the next byte is another id.
                    if (desc_len != '0) begin
                        value_length_next = desc_len;
                        bytes_left_next   = desc_len;
                        signed_next       = (desc[4:3] == SIGN_KIND_SIGNED);
                        exp_next          = desc[6:5];
                        acc_next          = '0;
                        if (in_last_reg) begin
                            res_fire   = 1'b1;
                            res_id     = in_byte_reg[ID_W-1:0];
                            res_status = ST_SHORT;
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                acc_next        = acc_merged;
                bytes_left_next = left_dec;
                if (left_dec == '0) begin
                    res_fire   = 1'b1;
                    res_raw    = {1'b0, acc_merged} | ((signed_reg && top_bit) ? ext_mask : '0);
                    res_exp    = exp_reg;
                    res_status = ST_MEASURE;
                    phase_next = PH_EXPECT;
                end else if (in_last_reg) begin
                    res_fire   = 1'b1;
                    res_status = ST_SHORT;
                end
            end
            default:
            begin
                // Dropping the remainder of a bad payload.
                phase_next = phase_reg;
            end
        endcase

        // Every tlast byte ends the payload; the next byte starts a new one.
        if (in_last_reg) begin
            phase_next = PH_EXPECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_EXPECT;
            cur_id_reg       <= '0;
            bytes_left_reg   <= '0;
            value_length_reg <= '0;
            acc_reg          <= '0;
            signed_reg       <= 1'b0;
            exp_reg          <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= take && res_fire;
            end
            if (take) begin
                phase_reg        <= phase_next;
                cur_id_reg       <= cur_id_next;
                bytes_left_reg   <= bytes_left_next;
                value_length_reg <= value_length_next;
                acc_reg          <= acc_next;
                signed_reg       <= signed_next;
                exp_reg          <= exp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (take && res_fire) begin
            out_id_reg     <= res_id;
            out_raw_reg    <= res_raw;
            out_exp_reg    <= res_exp;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-ID_W-RAW_W-EXP_W){1'b0}},
                            out_exp_reg, out_raw_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;

    // Error results never carry a value or an exponent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_MEASURE) |->
            (m_axis_tdata[ID_W+RAW_W+EXP_W-1:ID_W] == '0))
        else $error("error result carries a value or exponent");

    // A measurement always belongs to an id that the descriptor table knows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_MEASURE) |->
            (int'(m_axis_tdata[ID_W-1:0]) < ROM_DEPTH))
        else $error("measurement result with an unknown id");

    // A tlast byte always leaves the parser waiting for a fresh id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last_reg) |=> (phase_reg == PH_EXPECT))
        else $error("parser not reset to id phase after tlast");

    // While value bytes are expected, the remaining count is within the object length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE) |->
            (bytes_left_reg != '0 && bytes_left_reg <= value_length_reg))
        else $error("remaining byte count out of range");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for ble_sensor_object_parser_top: streams payload bytes in and checks
// every decoded object against an in-bench parse model. Depends on bsop_pkg and the top level.
`timescale 1ns / 1ps

// The bench feeds service-data payloads one byte per item on the slave stream and keeps its
// own copy of the parse state. A monitor sees every accepted byte and runs the byte through
// the bench's parse model, which queues the object that the byte completes, if any. A second
// monitor takes each result item off the master stream and compares it, field by field,
// with the oldest queued object. The stimulus is a short directed run over the corner cases,
// then mostly well-formed random payloads with random idling on both sides, then a phase in
// which the receiver holds off long enough for the block to fill up and stall its input.
module tb;

    import bsop_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 10;

    // Object descriptor table kept by the bench: length in bits 2..0, sign kind in
    // bits 4..3, decimal exponent in bits 6..5.
    localparam logic [7:0] OBJ_DESC [0:ROM_DEPTH-1] = '{
        8'h01, 8'h01, 8'h4A, 8'h42, 8'h43, 8'h43, 8'h42, 8'h42,
        8'h4A, 8'h01, 8'h63, 8'h43, 8'h62, 8'h02, 8'h02, 8'h01,
        8'h01, 8'h01, 8'h02, 8'h02, 8'h42, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h04, 8'h2A,
        8'h02, 8'h22, 8'h63, 8'h62, 8'h42, 8'h2A, 8'h21, 8'h22,
        8'h02, 8'h62, 8'h22, 8'h63, 8'h64, 8'h64, 8'h64, 8'h64
    };

    // One decoded or faulty object as it leaves the block.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [RAW_W-1:0] raw;
        logic [EXP_W-1:0] expo;
        status_t          st;
    } sensor_object_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    // Parse state of the bench model, at its reset values.
    phase_t             pm_phase  = PH_EXPECT;
    logic [ID_W-1:0]    pm_id     = '0;
    logic [LEN_W-1:0]   pm_left   = '0;
    logic [LEN_W-1:0]   pm_len    = '0;
    logic [VALUE_W-1:0] pm_acc    = '0;
    logic               pm_signed = 1'b0;
    logic [EXP_W-1:0]   pm_exp    = '0;

    sensor_object_t expected_objects [$];
    sensor_object_t seen_object;
    sensor_object_t due_object;
    sensor_object_t next_object;
    logic [7:0]     payload_bytes [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  bytes_sent     = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    logic hold_sink     = 1'b0;

    ble_sensor_object_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Runs one payload byte through the parse model. Returns 1 when the byte yields a
    // result item, which is then left in obj.
    function automatic bit parse_payload_byte(input logic [7:0] b, input logic last,
                                              output sensor_object_t obj);
        logic [7:0]       desc;
        logic [LEN_W-1:0] done;
        int               top;
        bit               emit;
        emit = 1'b0;
        obj  = '0;
        case (pm_phase)
            PH_EXPECT:
            begin
                if (int'(b) >= ROM_DEPTH)
                begin
                    // Unknown id: report it and drop the rest of the payload.
                    obj.id   = b[ID_W-1:0];
                    obj.st   = ST_UNKNOWN;
                    emit     = 1'b1;
                    pm_phase = PH_DROP;
                end
                else
                begin
                    desc  = OBJ_DESC[b[ID_W-1:0]];
                    pm_id = b[ID_W-1:0];
                    // Zero-length ids leave the rest of the state untouched.
                    if (desc[2:0] != 3'd0)
                    begin
                        pm_len    = desc[2:0];
                        pm_left   = desc[2:0];
                        pm_signed = (desc[4:3] == SIGN_KIND_SIGNED);
                        pm_exp    = desc[6:5];
                        pm_acc    = '0;
                        if (last)
                        begin
                            obj.id = b[ID_W-1:0];
                            obj.st = ST_SHORT;
                            emit   = 1'b1;
                        end
                        else
                        begin
                            pm_phase = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                // Little-endian: the n-th value byte lands in byte lane n.
                done    = pm_len - pm_left;
                pm_acc  = pm_acc | ({24'd0, b} << (8 * done[1:0]));
                pm_left = pm_left - 3'd1;
                if (pm_left == 3'd0)
                begin
                    obj.id   = pm_id;
                    obj.raw  = {1'b0, pm_acc};
                    obj.expo = pm_exp;
                    obj.st   = ST_MEASURE;
                    top      = (pm_len >= 3'd1 && pm_len <= 3'd4) ? 8 * pm_len - 1 : 31;
                    if (pm_signed && pm_acc[top])
                    begin
                        for (int k = top + 1; k < RAW_W; k++)
                        begin
                            obj.raw[k] = 1'b1;
                        end
                    end
                    emit     = 1'b1;
                    pm_phase = PH_EXPECT;
                end
                else if (last)
                begin
                    obj.id = pm_id;
                    obj.st = ST_SHORT;
                    emit   = 1'b1;
                end
            end
            default:
            begin
                // Dropping the remainder of a faulty payload.
            end
        endcase
        if (last)
        begin
            pm_phase = PH_EXPECT;
        end
        return emit;
    endfunction

    // Every byte the block accepts goes through the parse model here.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (parse_payload_byte(s_axis_tdata, s_axis_tlast, next_object))
            begin
                expected_objects.push_back(next_object);
            end
        end
    end

    // Every result item the block hands over is compared with the oldest expected object.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_object.id   = m_axis_tdata[6:0];
            seen_object.raw  = m_axis_tdata[39:7];
            seen_object.expo = m_axis_tdata[41:40];
            seen_object.st   = status_t'(m_axis_tuser);
            if (expected_objects.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: result with nothing expected: id %0d raw %h exp %0d status %0d",
                             $time, seen_object.id, seen_object.raw, seen_object.expo,
                             seen_object.st);
                end
            end
            else
            begin
                due_object = expected_objects.pop_front();
                if (seen_object.id !== due_object.id || seen_object.raw !== due_object.raw ||
                    seen_object.expo !== due_object.expo || seen_object.st !== due_object.st)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch: expected id %0d raw %h exp %0d status %0d",
                                 $time, due_object.id, due_object.raw, due_object.expo,
                                 due_object.st);
                        $display("%0t:           actual id %0d raw %h exp %0d status %0d",
                                 $time, seen_object.id, seen_object.raw, seen_object.expo,
                                 seen_object.st);
                    end
                end
            end
        end
    end

    // Receiver: random stalls at the current rate, or held off completely on request.
    always @(posedge clk)
    begin
        m_axis_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one byte, after a random idle gap, and returns at the edge that accepts it.
    // tvalid stays high after acceptance so back-to-back items need no extra edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Sends the bytes queued in payload_bytes as one payload, tlast on the final byte.
    task automatic send_payload();
        foreach (payload_bytes[i])
        begin
            send_byte(payload_bytes[i], i == payload_bytes.size() - 1);
        end
        payload_bytes.delete();
    endtask

    // Builds and sends one random payload. Most are runs of well-formed objects; some end
    // early, some carry unknown ids with trailing bytes, and a few are plain noise.
    task automatic send_random_payload();
        int         n_obj;
        int         kind;
        int         len;
        int         cut;
        logic [7:0] id;
        logic [7:0] v;
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(1, 12))
            begin
                payload_bytes.push_back(8'($urandom));
            end
        end
        else
        begin
            n_obj = $urandom_range(1, 6);
            repeat (n_obj)
            begin
                kind = $urandom_range(99);
                if (kind < 82)
                begin
                    do
                    begin
                        id = 8'($urandom_range(ROM_DEPTH - 1));
                    end
                    while (OBJ_DESC[id[ID_W-1:0]][2:0] == 3'd0);
                end
                else if (kind < 92)
                begin
                    id = 8'($urandom_range(48, 60));
                end
                else
                begin
                    id = 8'($urandom_range(ROM_DEPTH, 255));
                end
                payload_bytes.push_back(id);
                // Behind an unknown id the bytes are junk that the block should drop.
                len = (int'(id) < ROM_DEPTH) ? int'(OBJ_DESC[id[ID_W-1:0]][2:0])
                                             : $urandom_range(3);
                repeat (len)
                begin
                    v = 8'($urandom);
                    // A quarter of the value bytes are 00, FF, 7F or 80.
                    if ($urandom_range(3) == 0)
                    begin
                        v = {8{v[0]}} ^ {1'b0, {7{v[1]}}};
                    end
                    payload_bytes.push_back(v);
                end
            end
            if ($urandom_range(99) < 8)
            begin
                cut = $urandom_range(1, payload_bytes.size());
                while (payload_bytes.size() > cut)
                begin
                    void'(payload_bytes.pop_back());
                end
            end
        end
        send_payload();
    endtask

    // Each value length, mostly at its extremes, signed and unsigned ids, every status and the
    // zero-length, unknown-id and early-end cases, all without idling.
    task automatic test_directed_objects();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // id 0 = 255, id 2 = -32768, id 4 = 0x123456, id 62 = 0xFFFFFFFF
        payload_bytes = '{8'h00, 8'hFF, 8'h02, 8'h00, 8'h80, 8'h04, 8'h56, 8'h34, 8'h12,
                          8'h3E, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_payload();
        // Zero-length id followed by a positive signed value.
        payload_bytes = '{8'h30, 8'h3F, 8'h00, 8'h7F};
        send_payload();
        // Unknown id with a byte to drop, then an unknown id with all bits set.
        payload_bytes = '{8'h50, 8'h01};
        send_payload();
        payload_bytes = '{8'hFF};
        send_payload();
        // Payload ending on a known id byte, then one ending inside a value.
        payload_bytes = '{8'h03};
        send_payload();
        payload_bytes = '{8'h4C, 8'h11};
        send_payload();
        // A zero-length id alone gives no result.
        payload_bytes = '{8'h38};
        send_payload();
    endtask

    task automatic test_random_payloads(input int src_pct, input int sink_pct, input int n_bytes);
        int stop_at;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            send_random_payload();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering bytes, so
    // the result path fills up and the block has to stall its input.
    task automatic test_output_backpressure();
        int stop_at;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fork
            begin
                hold_sink <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink <= 1'b0;
            end
        join_none
        stop_at = bytes_sent + 80;
        while (bytes_sent < stop_at)
        begin
            send_random_payload();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_objects();
        test_random_payloads(0, 0, 500);
        test_random_payloads(59, 0, 500);
        test_random_payloads(0, 59, 500);
        test_random_payloads(11, 11, 500);
        test_output_backpressure();

        s_axis_tvalid  <= 1'b0;
        sink_stall_pct = 0;
        while (expected_objects.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_objects.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
